FILE: rtl/pvn_pkg.sv
package pvn_pkg;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int VAL_W     = 16;
  localparam int MEAN_W    = 18;
  localparam int INV_W     = 24;
  localparam int INV_HALF  = 12;
  localparam int DIV_W     = 64;
  localparam int SQRT_W    = 32;
  localparam int MEAN_FRAC = 10;
  localparam int INV_FRAC  = 16;
  localparam int PROD_W    = MEAN_W + INV_HALF;
  localparam int ACC_W     = MEAN_W + INV_W + 1;

  localparam logic [CFG_W-1:0] COLS_RESET = 6'd24;
  localparam logic [CFG_W-1:0] ROWS_RESET = 6'd24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATCH_COLS = 2'd0,
    REG_PATCH_ROWS = 2'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FLAT      = 2'd1,
    STAT_NOT_READY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_DRAIN = 2'd1
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PROD,
    ST_DIFF,
    ST_DIV_MEAN,
    ST_MEAN,
    ST_DIV_INV,
    ST_SQRT_GO,
    ST_SQRT,
    ST_INV,
    ST_RD,
    ST_MAG,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_OUT,
    ST_NOT_READY
  } state_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic fin_mul;
    logic fin_d;
    logic mean_cap;
    logic flat_fin;
    logic ndiv_start;
    logic sqrt_start;
    logic inv_cap;
    logic drain_rd;
    logic drain_mag;
    logic drain_lo;
    logic drain_hi;
    logic drain_out;
    logic not_ready_out;
  } cmd_t;

  typedef struct packed {
    logic ready;
    logic complete;
    logic flat;
    logic div_done;
    logic sqrt_done;
    logic out_valid;
  } sts_t;

endpackage

FILE: rtl/pvn_div.sv
module pvn_div
  import pvn_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  output logic [DIV_W-1:0] quo,
  output logic             done
);

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W:0]   rem;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   rem_next;
  logic [DIV_W-1:0] den_q;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             ge;

  // restoring division, one quotient bit a cycle
  always_comb begin
    rem_sh   = {rem[DIV_W-1:0], quo[DIV_W-1]};
    ge       = rem_sh >= {1'b0, den_q};
    rem_next = ge ? rem_sh - {1'b0, den_q} : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= num;
        den_q <= den;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[DIV_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/pvn_sqrt.sv
module pvn_sqrt
  import pvn_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_W-1:0]  value,
  output logic [SQRT_W-1:0] root_out,
  output logic              done
);

  logic [DIV_W-1:0] v;
  logic [DIV_W-1:0] root;
  logic [DIV_W-1:0] bit_q;
  logic [DIV_W-1:0] trial;
  logic             busy;

  assign trial    = root + bit_q;
  assign root_out = root[SQRT_W-1:0];

  // digit-by-digit root, two radicand bits a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        v     <= value;
        root  <= '0;
        bit_q <= {2'b01, {(DIV_W-2){1'b0}}};
      end else if (busy) begin
        if (v >= trial) begin
          v    <= v - trial;
          root <= (root >> 1) + bit_q;
        end else begin
          root <= root >> 1;
        end
        bit_q <= bit_q >> 2;
        if (bit_q[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/pvn_datapath.sv
module pvn_datapath
  import pvn_pkg::*;
#(
  parameter int MAX_SIDE = 32
)(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_val,
  input  logic [PIX_W-1:0]     pixel_in,
  input  logic                 out_take,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  output logic [VAL_W-1:0]     out_value,
  output logic [1:0]           out_status,
  output logic                 out_last
);

  localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + PIX_W;
  localparam int SQ_W   = CNT_W + 2 * PIX_W;
  localparam int D_W    = CNT_W + SQ_W;
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int R_W    = ACC_W - INV_FRAC;

  logic [CFG_W-1:0]   cols;
  logic [CFG_W-1:0]   rows;
  logic [SIDE_W-1:0]  side_c;
  logic [SIDE_W-1:0]  side_r;
  logic [CNT_W-1:0]   area;

  logic [PIX_W-1:0]   pixel_q;
  logic [PIX_W-1:0]   mem [DEPTH];
  logic [PIX_W-1:0]   rd_data;

  logic [SUM_W-1:0]   sum;
  logic [SQ_W-1:0]    sq;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_after;
  logic               has_room;
  logic [CNT_W-1:0]   didx;
  logic [MEAN_W-1:0]  mean;
  logic [INV_W-1:0]   inv;
  logic               ready;

  logic [D_W-1:0]     p1;
  logic [D_W-1:0]     p2;
  logic [D_W-1:0]     p1_w;
  logic [D_W-1:0]     p2_w;
  logic [D_W-1:0]     d;
  logic [2*CNT_W-1:0] area2;
  logic [2*CNT_W-1:0] area2_w;
  logic [2*PIX_W-1:0] pix_sq;

  logic               div_start;
  logic [DIV_W-1:0]   div_num;
  logic [DIV_W-1:0]   div_den;
  logic [DIV_W-1:0]   quo;
  logic               div_done;
  logic [SQRT_W-1:0]  root;
  logic               sqrt_done;

  logic [MEAN_W-1:0]  pscaled;
  logic [MEAN_W-1:0]  mag;
  logic               neg;
  logic [PROD_W-1:0]  prod_lo;
  logic [PROD_W-1:0]  prod_hi;
  logic [ACC_W-1:0]   total;
  logic [R_W-1:0]     r;
  logic [VAL_W-1:0]   val;
  logic               last;
  logic               out_valid;

  // side clamping: zero acts as one, anything above the limit as the limit
  always_comb begin
    if (cols == '0) side_c = SIDE_W'(1);
    else if (int'(cols) > MAX_SIDE) side_c = SIDE_W'(MAX_SIDE);
    else side_c = SIDE_W'(cols);
    if (rows == '0) side_r = SIDE_W'(1);
    else if (int'(rows) > MAX_SIDE) side_r = SIDE_W'(MAX_SIDE);
    else side_r = SIDE_W'(rows);
  end

  assign area        = CNT_W'(side_c) * CNT_W'(side_r);
  assign has_room    = count < CNT_W'(DEPTH);
  assign count_after = count + CNT_W'(has_room);
  assign pix_sq      = pixel_q * pixel_q;
  assign p1_w        = count * sq;
  assign p2_w        = sum * sum;
  assign area2_w     = count * count;

  // shared divider: mean first, then area^2 * 2^32 / D
  always_comb begin
    div_start = cmd.fin_d | cmd.ndiv_start;
    if (cmd.fin_d) begin
      div_num = (DIV_W'(sum) << MEAN_FRAC) + DIV_W'(count >> 1);
      div_den = DIV_W'(count);
    end else begin
      div_num = DIV_W'(area2) << 32;
      div_den = DIV_W'(d);
    end
  end

  pvn_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (quo),
    .done  (div_done)
  );

  pvn_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .value    (quo),
    .root_out (root),
    .done     (sqrt_done)
  );

  // output rounding and saturation
  always_comb begin
    pscaled = {rd_data, {MEAN_FRAC{1'b0}}};
    total   = ACC_W'(prod_lo) + (ACC_W'(prod_hi) << INV_HALF)
              + (ACC_W'(1) << (INV_FRAC - 1));
    r       = total[ACC_W-1:INV_FRAC];
    if (neg) begin
      if (r > R_W'(32768)) val = 16'h8000;
      else val = VAL_W'(-r);
    end else begin
      if (r > R_W'(32767)) val = 16'h7FFF;
      else val = VAL_W'(r);
    end
    last = ({1'b0, didx} + 1'b1) >= {1'b0, count};
  end

  always_ff @(posedge clk) begin
    if (cmd.load && has_room) mem[count[ADDR_W-1:0]] <= pixel_q;
    if (cmd.drain_rd) rd_data <= mem[didx[ADDR_W-1:0]];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) pixel_q <= pixel_in;
    if (cmd.fin_mul) begin
      p1    <= p1_w;
      p2    <= p2_w;
      area2 <= area2_w;
    end
    if (cmd.fin_d) d <= p1 - p2;
    if (cmd.drain_mag) begin
      neg <= pscaled < mean;
      mag <= (pscaled < mean) ? mean - pscaled : pscaled - mean;
    end
    if (cmd.drain_lo) prod_lo <= mag * inv[INV_HALF-1:0];
    if (cmd.drain_hi) prod_hi <= mag * inv[INV_W-1:INV_HALF];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cols      <= COLS_RESET;
      rows      <= ROWS_RESET;
      sum       <= '0;
      sq        <= '0;
      count     <= '0;
      didx      <= '0;
      mean      <= '0;
      inv       <= '0;
      ready     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_PATCH_COLS: cols <= cfg_val;
          REG_PATCH_ROWS: rows <= cfg_val;
          default: ;
        endcase
      end
      if (out_take) out_valid <= 1'b0;
      if (cmd.load && has_room) begin
        count <= count + 1'b1;
        sum   <= sum + SUM_W'(pixel_q);
        sq    <= sq + SQ_W'(pix_sq);
      end
      if (cmd.mean_cap) mean <= MEAN_W'(quo);
      if (cmd.flat_fin) begin
        inv   <= '0;
        ready <= 1'b1;
        didx  <= '0;
      end
      if (cmd.inv_cap) begin
        inv   <= (root > SQRT_W'({INV_W{1'b1}})) ? {INV_W{1'b1}} : root[INV_W-1:0];
        ready <= 1'b1;
        didx  <= '0;
      end
      if (cmd.drain_out) begin
        out_valid  <= 1'b1;
        out_last   <= last;
        if (inv == '0) begin
          out_value  <= '0;
          out_status <= STAT_FLAT;
        end else begin
          out_value  <= val;
          out_status <= STAT_OK;
        end
        if (last) begin
          sum   <= '0;
          sq    <= '0;
          count <= '0;
          didx  <= '0;
          mean  <= '0;
          inv   <= '0;
          ready <= 1'b0;
        end else begin
          didx <= didx + 1'b1;
        end
      end
      if (cmd.not_ready_out) begin
        out_valid  <= 1'b1;
        out_value  <= '0;
        out_status <= STAT_NOT_READY;
        out_last   <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.ready     = ready;
    sts.complete  = count_after >= area;
    sts.flat      = d == '0;
    sts.div_done  = div_done;
    sts.sqrt_done = sqrt_done;
    sts.out_valid = out_valid;
  end

endmodule

FILE: rtl/pvn_ctrl.sv
module pvn_ctrl
  import pvn_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_op,
  input  logic out_ready,
  input  sts_t sts,
  output logic in_ready,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE) && (!sts.out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_DRAIN[0]) state_next = sts.ready ? ST_RD : ST_NOT_READY;
          else state_next = sts.ready ? ST_IDLE : ST_LOAD;
        end
      end
      ST_LOAD:      state_next = sts.complete ? ST_PROD : ST_IDLE;
      ST_PROD:      state_next = ST_DIFF;
      ST_DIFF:      state_next = ST_DIV_MEAN;
      ST_DIV_MEAN:  if (sts.div_done) state_next = ST_MEAN;
      ST_MEAN:      state_next = sts.flat ? ST_IDLE : ST_DIV_INV;
      ST_DIV_INV:   if (sts.div_done) state_next = ST_SQRT_GO;
      ST_SQRT_GO:   state_next = ST_SQRT;
      ST_SQRT:      if (sts.sqrt_done) state_next = ST_INV;
      ST_INV:       state_next = ST_IDLE;
      ST_RD:        state_next = ST_MAG;
      ST_MAG:       state_next = ST_MUL_LO;
      ST_MUL_LO:    state_next = ST_MUL_HI;
      ST_MUL_HI:    state_next = ST_OUT;
      ST_OUT:       state_next = ST_IDLE;
      ST_NOT_READY: state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd               = '0;
    cmd.capture       = accept;
    cmd.load          = state == ST_LOAD;
    cmd.fin_mul       = state == ST_PROD;
    cmd.fin_d         = state == ST_DIFF;
    cmd.mean_cap      = state == ST_MEAN;
    cmd.flat_fin      = (state == ST_MEAN) && sts.flat;
    cmd.ndiv_start    = (state == ST_MEAN) && !sts.flat;
    cmd.sqrt_start    = state == ST_SQRT_GO;
    cmd.inv_cap       = state == ST_INV;
    cmd.drain_rd      = state == ST_RD;
    cmd.drain_mag     = state == ST_MAG;
    cmd.drain_lo      = state == ST_MUL_LO;
    cmd.drain_hi      = state == ST_MUL_HI;
    cmd.drain_out     = state == ST_OUT;
    cmd.not_ready_out = state == ST_NOT_READY;
  end

endmodule

FILE: rtl/patch_variance_normalizer_unit.sv
// channel   | direction | request contents
// s_*       | in        | tuser: op; tdata: pixel
// m_*       | out       | tdata: norm_value (Q5.10); tuser: status; tlast: last_pixel
// cfg_*     | in        | index 0 patch_cols, 1 patch_rows; data 6 bits
//
// each request finishes before the next is taken (one request in work at a time)
// the load that completes the patch also computes the mean and 1/std with the shared
// radix-2 divider (run twice, once for a flat patch) and the 2-bit-a-cycle root unit
// sync reset restores 24x24, clears the sums and returns to the loading phase
// the pixel store is not cleared; drains only read pixels loaded for the current patch
// an unaccepted result holds in the output register; new requests wait for it to leave
module patch_variance_normalizer_unit
  import pvn_pkg::*;
#(
  parameter int MAX_SIDE = 32
)(
  input  logic                 clk,
  input  logic                 rst,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // request stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [PIX_W-1:0]     s_tdata,   // [7:0] pixel
  input  logic                 s_tuser,   // [0] op
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [VAL_W-1:0]     m_tdata,   // [15:0] norm_value
  output logic [1:0]           m_tuser,   // [1:0] status
  output logic                 m_tlast    // last_pixel
);

  cmd_t cmd;
  sts_t sts;

  // config registers can always take a write
  assign cfg_ready = 1'b1;
  assign m_tvalid  = sts.out_valid;

  pvn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_op     (s_tuser),
    .out_ready (m_tready),
    .sts       (sts),
    .in_ready  (s_tready),
    .cmd       (cmd)
  );

  pvn_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_idx    (cfg_index),
    .cfg_val    (cfg_data),
    .pixel_in   (s_tdata),
    .out_take   (m_tready),
    .cmd        (cmd),
    .sts        (sts),
    .out_value  (m_tdata),
    .out_status (m_tuser),
    .out_last   (m_tlast)
  );

endmodule

FILE: rtl/pvn_checker.sv
module pvn_checker
  import pvn_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [VAL_W-1:0] m_tdata,
  input logic [1:0]       m_tuser,
  input logic             m_tlast
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser == STAT_OK || m_tuser == STAT_FLAT || m_tuser == STAT_NOT_READY)
    else $error("bad status code");

  a_flat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == STAT_FLAT || m_tuser == STAT_NOT_READY) |-> m_tdata == '0)
    else $error("nonzero value with flat or not-ready status");

  a_nrdy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == STAT_NOT_READY |-> !m_tlast)
    else $error("not-ready result marked last");

  // a request is never taken while a stalled result waits
  a_block: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("request accepted behind stalled result");

endmodule

bind patch_variance_normalizer_unit pvn_checker u_pvn_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
